// ===== hw/rtl/can_multi_frame_reassembler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// can_multi_frame_reassembler_unit_defines
// assertion macros used by the checker file of the reassembler
// ----------------------------------------------------------------------------
`ifndef CAN_MULTI_FRAME_REASSEMBLER_UNIT_DEFINES_SVH
`define CAN_MULTI_FRAME_REASSEMBLER_UNIT_DEFINES_SVH

// same-cycle implication, switched off while reset is held
`define CAN_MFR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("can_mfr check failed");

// next-cycle implication, switched off while reset is held
`define CAN_MFR_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("can_mfr check failed");

// next-cycle implication that also covers the reset cycles
`define CAN_MFR_ASSERT_RST(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("can_mfr reset check failed");

`endif

// ===== hw/rtl/can_mfr_pkg.sv =====
// ----------------------------------------------------------------------------
// can_mfr_pkg
// types and constants shared by the CAN multi-frame reassembler modules
// ----------------------------------------------------------------------------
package can_mfr_pkg;

  // frame geometry
  localparam logic [3:0]  FULL_LEN   = 4'd8;
  localparam int unsigned DIRECT_MAX = 6;

  // fill count of the payload store, never above 63 bytes
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned FILL_MAX = (1 << FILL_W) - 1;

  // timeout register
  localparam int unsigned TMO_W         = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // one message to emit: either the frame bytes carried along or the store
  typedef struct packed {
    logic                        from_store;
    logic [7:0]                  node_id;
    logic [7:0]                  command;
    logic [FILL_W-1:0]           count;
    logic [DIRECT_MAX-1:0][7:0]  bytes;
  } emit_cmd_t;

  // write port into the payload store
  typedef struct packed {
    logic              en;
    logic [FILL_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

// ===== hw/rtl/can_mfr_if.sv =====
// ----------------------------------------------------------------------------
// can_mfr_if
// valid/ready channels for received frames and for message bytes
// ----------------------------------------------------------------------------
interface can_mfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_node;
  logic [7:0]  frame_seq;
  logic [3:0]  frame_len;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [7:0]  byte6;
  logic [7:0]  byte7;
  logic [31:0] now_ms;

  modport source (
    output valid, frame_node, frame_seq, frame_len,
    output byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, now_ms,
    input  ready
  );

  modport sink (
    input  valid, frame_node, frame_seq, frame_len,
    input  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7, now_ms,
    output ready
  );
endinterface

interface can_mfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_id;
  logic [7:0] command;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (
    output valid, node_id, command, payload_byte, byte_valid, last_byte,
    input  ready
  );

  modport sink (
    input  valid, node_id, command, payload_byte, byte_valid, last_byte,
    output ready
  );
endinterface

// ===== hw/rtl/can_multi_frame_reassembler_unit.sv =====
// path: a single-frame message passes the front's frame registers, the queue and the
//   back's message register; a closing frame of an assembly first writes its bytes
//   to the store (one store write per byte), then adds a store read; the front takes
//   one frame at a time; message bytes leave at one per cycle while the sink is ready;
//   a stored message holds off new frames while the store is read out to its last byte
// reset: synchronous, active low; assembly cleared, timeout back to 100 ms
// ----------------------------------------------------------------------------
// can_multi_frame_reassembler_unit
// reassembles multi-frame CAN messages and emits them byte by byte
// ----------------------------------------------------------------------------
module can_multi_frame_reassembler_unit import can_mfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  can_mfr_in_if.sink       in_frame,
  can_mfr_out_if.source    out_msg,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_wdata
);

  store_wr_t store_wr;
  logic      push_valid;
  logic      push_ready;
  emit_cmd_t push_data;
  logic      pop_valid;
  logic      pop_ready;
  emit_cmd_t pop_data;
  logic      store_done;

  // frame classification and store fill
  can_mfr_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_frame   (in_frame),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .store_wr   (store_wr),
    .q_valid    (push_valid),
    .q_ready    (push_ready),
    .q_data     (push_data),
    .store_done (store_done)
  );

  // decoupling queue
  can_mfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // store and byte emission
  can_mfr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .store_wr   (store_wr),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .out_msg    (out_msg),
    .store_done (store_done)
  );

endmodule

// ===== hw/rtl/can_mfr_queue.sv =====
// ----------------------------------------------------------------------------
// can_mfr_queue
// two-entry queue of emit commands between the front and back parts
// ----------------------------------------------------------------------------
module can_mfr_queue import can_mfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  emit_cmd_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output emit_cmd_t pop_data
);

  emit_cmd_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push_fire;
  logic              pop_fire;

  // handshake
  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // occupancy
  always_comb begin
    case ({push_fire, pop_fire})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // pointers, depth is a power of two so they wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/can_mfr_front.sv =====
// ----------------------------------------------------------------------------
// can_mfr_front
// takes frames, tracks the open assembly, appends bytes to the store and
// queues messages for emission
// ----------------------------------------------------------------------------
module can_mfr_front import can_mfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  can_mfr_in_if.sink         in_frame,
  input  logic               cfg_we,
  input  logic [TMO_W-1:0]   cfg_wdata,
  output store_wr_t          store_wr,
  output logic               q_valid,
  input  logic               q_ready,
  output emit_cmd_t          q_data,
  input  logic               store_done
);

  // the store keeps one byte less than its size, and at most the fill limit
  localparam int unsigned STORE_CAP =
    ((BUFFER_BYTES - 1) < FILL_MAX) ? (BUFFER_BYTES - 1) : FILL_MAX;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_APPEND = 4'b0010,
    F_TMO    = 4'b0100,
    F_PUSH   = 4'b1000
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic [TMO_W-1:0]  timeout_r, timeout_nxt;
  logic              assembling_r, assembling_nxt;
  logic [7:0]        asm_node_r, asm_node_nxt;
  logic [7:0]        asm_cmd_r, asm_cmd_nxt;
  logic [7:0]        last_seq_r, last_seq_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [31:0]       start_time_r, start_time_nxt;
  logic [31:0]       last_check_r, last_check_nxt;
  logic              lock_r, lock_nxt;
  logic              emit_store_r, emit_store_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [3:0]        len_r, len_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [7:0]        frm_node_r, frm_node_nxt;
  logic [7:0][7:0]   data_r, data_nxt;

  logic              in_fire;
  logic [3:0]        len_eff;
  logic              seq_match;
  logic              clear_asm;
  logic [31:0]       since_check;
  logic [31:0]       age;

  // input handshake: one frame at a time, held off while the store is read out
  assign in_frame.ready = (state_r == F_IDLE) && !lock_r;
  assign in_fire        = in_frame.valid && in_frame.ready;

  // frame classification
  assign len_eff   = (in_frame.frame_len > FULL_LEN) ? FULL_LEN : in_frame.frame_len;
  assign seq_match = assembling_r && (asm_node_r == in_frame.frame_node) &&
                     (asm_cmd_r == in_frame.byte0) &&
                     (({1'b0, last_seq_r} + 9'd1) == {1'b0, in_frame.frame_seq});

  // timeout arithmetic, modulo 2^32
  assign since_check = now_r - last_check_r;
  assign age         = now_r - start_time_r;

  // next-state logic
  always_comb begin
    state_nxt      = state_r;
    timeout_nxt    = timeout_r;
    assembling_nxt = assembling_r;
    asm_node_nxt   = asm_node_r;
    asm_cmd_nxt    = asm_cmd_r;
    last_seq_nxt   = last_seq_r;
    fill_nxt       = fill_r;
    start_time_nxt = start_time_r;
    last_check_nxt = last_check_r;
    lock_nxt       = lock_r;
    emit_store_nxt = emit_store_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    now_nxt        = now_r;
    frm_node_nxt   = frm_node_r;
    data_nxt       = data_r;
    clear_asm      = 1'b0;
    store_wr       = '0;
    q_valid        = 1'b0;
    q_data         = '0;

    if (cfg_we) begin
      timeout_nxt = cfg_wdata;
    end
    if (store_done) begin
      lock_nxt = 1'b0;
    end

    unique case (state_r)
      F_IDLE: begin
        if (in_fire && (len_eff != 4'd0)) begin
          frm_node_nxt = in_frame.frame_node;
          data_nxt     = {in_frame.byte7, in_frame.byte6, in_frame.byte5,
                          in_frame.byte4, in_frame.byte3, in_frame.byte2,
                          in_frame.byte1, in_frame.byte0};
          len_nxt      = len_eff;
          now_nxt      = in_frame.now_ms;
          idx_nxt      = 4'd1;
          if (in_frame.frame_seq == 8'd0) begin
            // sequence zero always starts afresh
            if (len_eff != FULL_LEN) begin
              clear_asm      = 1'b1;
              emit_store_nxt = 1'b0;
              state_nxt      = F_PUSH;
            end else begin
              assembling_nxt = 1'b1;
              asm_node_nxt   = in_frame.frame_node;
              asm_cmd_nxt    = in_frame.byte0;
              last_seq_nxt   = 8'd0;
              fill_nxt       = '0;
              start_time_nxt = in_frame.now_ms;
              emit_store_nxt = 1'b0;
              state_nxt      = F_APPEND;
            end
          end else if (seq_match) begin
            last_seq_nxt   = in_frame.frame_seq;
            emit_store_nxt = (len_eff != FULL_LEN);
            state_nxt      = F_APPEND;
          end else begin
            clear_asm = 1'b1;
          end
        end
      end

      // one byte a cycle into the store, bytes past the cap are dropped
      F_APPEND: begin
        if (idx_r < len_r) begin
          if (fill_r < FILL_W'(STORE_CAP)) begin
            store_wr.en   = 1'b1;
            store_wr.addr = fill_r;
            store_wr.data = data_r[idx_r[2:0]];
            fill_nxt      = fill_r + FILL_W'(1);
          end
          idx_nxt = idx_r + 4'd1;
        end else begin
          state_nxt = emit_store_r ? F_PUSH : F_TMO;
        end
      end

      // stale assembly check after a frame that gives no message
      F_TMO: begin
        if (assembling_r && (since_check >= {16'd0, timeout_r})) begin
          if (age > {16'd0, timeout_r}) begin
            clear_asm = 1'b1;
          end
          last_check_nxt = now_r;
        end
        state_nxt = F_IDLE;
      end

      // hand a message to the back part
      F_PUSH: begin
        q_valid = 1'b1;
        if (emit_store_r) begin
          q_data.from_store = 1'b1;
          q_data.node_id    = asm_node_r;
          q_data.command    = asm_cmd_r;
          q_data.count      = fill_r;
        end else begin
          q_data.from_store = 1'b0;
          q_data.node_id    = frm_node_r;
          q_data.command    = data_r[0];
          q_data.count      = FILL_W'(len_r - 4'd1);
          q_data.bytes      = data_r[6:1];
        end
        if (q_ready) begin
          if (emit_store_r) begin
            clear_asm = 1'b1;
            lock_nxt  = 1'b1;
          end
          state_nxt = F_IDLE;
        end
      end

      default: begin
        state_nxt = F_IDLE;
      end
    endcase

    if (clear_asm) begin
      assembling_nxt = 1'b0;
      asm_node_nxt   = '0;
      asm_cmd_nxt    = '0;
      last_seq_nxt   = '0;
      fill_nxt       = '0;
      start_time_nxt = '0;
    end
  end

  // control and assembly state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      timeout_r    <= TIMEOUT_RESET;
      assembling_r <= 1'b0;
      asm_node_r   <= '0;
      asm_cmd_r    <= '0;
      last_seq_r   <= '0;
      fill_r       <= '0;
      start_time_r <= '0;
      last_check_r <= '0;
      lock_r       <= 1'b0;
      emit_store_r <= 1'b0;
      idx_r        <= '0;
      len_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      timeout_r    <= timeout_nxt;
      assembling_r <= assembling_nxt;
      asm_node_r   <= asm_node_nxt;
      asm_cmd_r    <= asm_cmd_nxt;
      last_seq_r   <= last_seq_nxt;
      fill_r       <= fill_nxt;
      start_time_r <= start_time_nxt;
      last_check_r <= last_check_nxt;
      lock_r       <= lock_nxt;
      emit_store_r <= emit_store_nxt;
      idx_r        <= idx_nxt;
      len_r        <= len_nxt;
    end
  end

  // captured frame payload
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    frm_node_r <= frm_node_nxt;
    data_r     <= data_nxt;
  end

endmodule

// ===== hw/rtl/can_mfr_back.sv =====
// ----------------------------------------------------------------------------
// can_mfr_back
// holds the payload store and emits queued messages one byte per transfer
// ----------------------------------------------------------------------------
module can_mfr_back import can_mfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  store_wr_t     store_wr,
  input  logic          q_valid,
  output logic          q_ready,
  input  emit_cmd_t     q_data,
  can_mfr_out_if.source out_msg,
  output logic          store_done
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOAD = 3'b010,
    B_SHOW = 3'b100
  } back_state_t;

  logic [7:0]        store_mem [BUFFER_BYTES];
  back_state_t       state_r, state_nxt;
  emit_cmd_t         cur_r, cur_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [7:0]        rd_data_r;
  logic              rd_en;
  logic [FILL_W-1:0] rd_addr;
  logic              is_last;
  logic              has_bytes;
  logic              out_fire;

  assign has_bytes = (cur_r.count != '0);
  assign is_last   = !has_bytes || (idx_r == (cur_r.count - FILL_W'(1)));
  assign out_fire  = out_msg.valid && out_msg.ready;

  // result fields
  assign out_msg.valid      = (state_r == B_SHOW);
  assign out_msg.node_id    = cur_r.node_id;
  assign out_msg.command    = cur_r.command;
  assign out_msg.byte_valid = has_bytes;
  assign out_msg.last_byte  = is_last;
  assign out_msg.payload_byte = !has_bytes       ? 8'd0 :
                                cur_r.from_store ? rd_data_r :
                                cur_r.bytes[idx_r[2:0]];

  // emission sequencer, store reads run one address ahead of the transfer
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    q_ready    = 1'b0;
    store_done = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_nxt   = q_data;
          idx_nxt   = '0;
          state_nxt = (q_data.from_store && (q_data.count != '0)) ? B_LOAD : B_SHOW;
        end
      end

      B_LOAD: begin
        rd_en     = 1'b1;
        state_nxt = B_SHOW;
      end

      B_SHOW: begin
        if (out_fire) begin
          if (is_last) begin
            store_done = cur_r.from_store;
            state_nxt  = B_IDLE;
          end else begin
            idx_nxt = idx_r + FILL_W'(1);
            rd_en   = cur_r.from_store;
            rd_addr = idx_r + FILL_W'(1);
          end
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // current message
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store_mem[ADDR_W'(store_wr.addr)] <= store_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[ADDR_W'(rd_addr)];
    end
  end

endmodule

// ===== hw/rtl/can_mfr_checker.sv =====
// ----------------------------------------------------------------------------
// can_mfr_checker
// port-level checks on the message output of the reassembler
// ----------------------------------------------------------------------------
`include "can_multi_frame_reassembler_unit_defines.svh"

module can_mfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] node_id,
  input logic [7:0] command,
  input logic [7:0] payload_byte,
  input logic       byte_valid,
  input logic       last_byte
);

  // a stalled result holds still
  `CAN_MFR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(node_id) && $stable(command) && $stable(payload_byte) && $stable(last_byte))

  // an empty message is a single result with a zero byte
  `CAN_MFR_ASSERT_NOW(a_empty_msg, clk, rst_n, out_valid && !byte_valid, last_byte && (payload_byte == 8'd0))

  // bytes of one message follow back to back under the same node and command
  `CAN_MFR_ASSERT_NXT(a_msg_cont, clk, rst_n, out_valid && out_ready && !last_byte, out_valid && byte_valid && $stable(node_id) && $stable(command))

  // nothing is offered straight after reset
  `CAN_MFR_ASSERT_RST(a_rst_quiet, clk, !rst_n, !out_valid)

endmodule

bind can_multi_frame_reassembler_unit can_mfr_checker u_can_mfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_msg.valid),
  .out_ready    (out_msg.ready),
  .node_id      (out_msg.node_id),
  .command      (out_msg.command),
  .payload_byte (out_msg.payload_byte),
  .byte_valid   (out_msg.byte_valid),
  .last_byte    (out_msg.last_byte)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the CAN multi-frame reassembler against a cycle-free prediction of
// its message bytes; frames go in as bursts with gaps, the byte sink stalls
// on changing patterns, and the timeout register is swept between phases
// ----------------------------------------------------------------------------
module testbench;
  import can_mfr_pkg::*;

  localparam int unsigned BUFFER_BYTES    = 64;
  localparam int unsigned STORE_LIMIT     =
    (BUFFER_BYTES - 1 < FILL_MAX) ? BUFFER_BYTES - 1 : FILL_MAX;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned ITEMS_PER_PHASE = 16;

  // one received frame as the sender drives it
  typedef struct packed {
    logic [7:0]      node;
    logic [7:0]      seq;
    logic [3:0]      len;
    logic [7:0][7:0] data;
    logic [31:0]     now;
  } frame_t;

  // one message byte as it leaves the block
  typedef struct packed {
    logic [7:0] node_id;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last_byte;
  } msg_byte_t;

  // prediction of the reassembly and the queue of bytes still to come
  class message_scoreboard;
    logic [15:0]  timeout;
    logic         assembling;
    logic [7:0]   asm_node;
    logic [7:0]   asm_cmd;
    logic [7:0]   last_seq;
    int unsigned  fill;
    logic [31:0]  start_ms;
    logic [31:0]  check_ms;
    logic [7:0]   store [BUFFER_BYTES];
    msg_byte_t    expected_bytes [$];
    int unsigned  faults;

    function new();
      timeout  = TIMEOUT_RESET;
      check_ms = '0;
      faults   = 0;
      drop_assembly();
    endfunction

    function void drop_assembly();
      assembling = 1'b0;
      asm_node   = '0;
      asm_cmd    = '0;
      last_seq   = '0;
      fill       = 0;
      start_ms   = '0;
    endfunction

    // an empty message still gives one byte, marked as holding no data
    function void emit_message(logic [7:0] node, logic [7:0] cmd, logic [7:0] bytes [$]);
      if (bytes.size() == 0) begin
        expected_bytes.push_back('{node, cmd, 8'h00, 1'b0, 1'b1});
      end else begin
        foreach (bytes[i])
          expected_bytes.push_back('{node, cmd, bytes[i], 1'b1, i == bytes.size() - 1});
      end
    endfunction

    function void note_frame(frame_t f);
      int unsigned n;
      logic [7:0]  bytes [$];
      n = f.len;
      // zero-length frames leave everything untouched
      if (n == 0) return;
      if (n > FULL_LEN) n = FULL_LEN;
      if (f.seq == 8'd0) begin
        drop_assembly();
        // short first frame is a whole message
        if (n < FULL_LEN) begin
          for (int i = 1; i < n; i++) bytes.push_back(f.data[i]);
          emit_message(f.node, f.data[0], bytes);
          return;
        end
        asm_node = f.node;
        asm_cmd  = f.data[0];
        last_seq = 8'd0;
        start_ms = f.now;
        for (int i = 1; i < n && fill < STORE_LIMIT; i++) begin
          store[fill] = f.data[i];
          fill++;
        end
        assembling = 1'b1;
      end else if (assembling && asm_node == f.node && asm_cmd == f.data[0] &&
                   {1'b0, last_seq} + 9'd1 == {1'b0, f.seq}) begin
        // bytes past the store limit are dropped, the frame still counts
        for (int i = 1; i < n; i++) begin
          if (fill < STORE_LIMIT) begin
            store[fill] = f.data[i];
            fill++;
          end
        end
        last_seq = f.seq;
        if (n < FULL_LEN) begin
          for (int i = 0; i < fill; i++) bytes.push_back(store[i]);
          emit_message(asm_node, asm_cmd, bytes);
          drop_assembly();
          return;
        end
      end else begin
        drop_assembly();
      end
      // stale assembly check, only after frames that gave nothing
      if (assembling && (f.now - check_ms) >= 32'(timeout)) begin
        if ((f.now - start_ms) > 32'(timeout)) drop_assembly();
        check_ms = f.now;
      end
    endfunction

    function void check_byte(msg_byte_t got);
      msg_byte_t exp;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected message byte %h", $time, got);
        faults++;
        return;
      end
      exp = expected_bytes.pop_front();
      if (got.node_id != exp.node_id) begin
        $display("%0t: node_id expected %h got %h", $time, exp.node_id, got.node_id);
        faults++;
      end
      if (got.command != exp.command) begin
        $display("%0t: command expected %h got %h", $time, exp.command, got.command);
        faults++;
      end
      if (got.payload_byte != exp.payload_byte) begin
        $display("%0t: payload_byte expected %h got %h", $time, exp.payload_byte,
                 got.payload_byte);
        faults++;
      end
      if (got.byte_valid != exp.byte_valid) begin
        $display("%0t: byte_valid expected %b got %b", $time, exp.byte_valid,
                 got.byte_valid);
        faults++;
      end
      if (got.last_byte != exp.last_byte) begin
        $display("%0t: last_byte expected %b got %b", $time, exp.last_byte, got.last_byte);
        faults++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [TMO_W-1:0] cfg_wdata;

  can_mfr_in_if  frame_ch ();
  can_mfr_out_if msg_ch ();

  message_scoreboard sb;
  logic [31:0]       clock_ms;
  int unsigned       items_sent;
  int unsigned       burst_left;

  can_multi_frame_reassembler_unit #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_frame  (frame_ch),
    .out_msg   (msg_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // millisecond advance: mostly short, sometimes right at the timeout
  function automatic logic [31:0] pick_step();
    int unsigned t;
    t = sb.timeout;
    case ($urandom_range(0, 9))
      0, 1, 2:    return 32'd0;
      3, 4, 5, 6: return $urandom_range(0, t / 4);
      7, 8:       return (t == 0) ? $urandom_range(0, 1) : t - 1 + $urandom_range(0, 2);
      default:    return $urandom;
    endcase
  endfunction

  function automatic frame_t make_frame(logic [7:0] node, logic [7:0] seq, logic [3:0] len,
                                        logic [7:0] cmd, logic [31:0] step);
    frame_t f;
    f.node    = node;
    f.seq     = seq;
    f.len     = len;
    f.data    = {$urandom, $urandom};
    f.data[0] = cmd;
    clock_ms  = clock_ms + step;
    f.now     = clock_ms;
    return f;
  endfunction

  // one frame transfer; called and left just after a falling edge
  task automatic send_frame(frame_t f);
    if (burst_left == 0) begin
      frame_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    frame_ch.valid      = 1'b1;
    frame_ch.frame_node = f.node;
    frame_ch.frame_seq  = f.seq;
    frame_ch.frame_len  = f.len;
    frame_ch.byte0      = f.data[0];
    frame_ch.byte1      = f.data[1];
    frame_ch.byte2      = f.data[2];
    frame_ch.byte3      = f.data[3];
    frame_ch.byte4      = f.data[4];
    frame_ch.byte5      = f.data[5];
    frame_ch.byte6      = f.data[6];
    frame_ch.byte7      = f.data[7];
    frame_ch.now_ms     = f.now;
    do @(posedge clk); while (!frame_ch.ready);
    sb.note_frame(f);
    if (f.len != 0) items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // opening frame, full continuations and a short closing frame,
  // optionally with one frame spoilt
  task automatic send_message(logic [7:0] node, logic [7:0] cmd, int unsigned nfull,
                              logic [3:0] close_len, bit broken);
    frame_t      f;
    int unsigned bad;
    logic [3:0]  len;
    bad = broken ? $urandom_range(1, nfull + 1) : 0;
    for (int k = 0; k <= nfull + 1; k++) begin
      if (k <= nfull) len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : FULL_LEN;
      else len = close_len;
      f = make_frame(node, 8'(k), len, cmd, pick_step());
      if (broken && (k == bad)) begin
        case ($urandom_range(0, 2))
          0:       f.node    = f.node ^ 8'($urandom_range(1, 255));
          1:       f.data[0] = f.data[0] ^ 8'($urandom_range(1, 255));
          default: f.seq     = f.seq + 8'($urandom_range(1, 255));
        endcase
      end
      send_frame(f);
    end
  endtask

  // let the block drain before touching the register or finishing
  task automatic settle();
    frame_ch.valid = 1'b0;
    burst_left     = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(logic [TMO_W-1:0] value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    sb.timeout = value;
  endtask

  task automatic run_directed();
    frame_t f;
    // empty message and an all-ones single frame
    send_frame(make_frame(8'h00, 8'd0, 4'd1, 8'h00, 32'd0));
    f      = make_frame(8'hFF, 8'd0, 4'd7, 8'hFF, 32'd0);
    f.data = '1;
    send_frame(f);
    // zero-length frame is ignored
    send_frame(make_frame(8'h12, 8'd0, 4'd0, 8'h34, 32'd0));
    // over-long length counts as a full frame
    send_frame(make_frame(8'h05, 8'd0, 4'd15, 8'h09, 32'd0));
    send_frame(make_frame(8'h05, 8'd1, 4'd2, 8'h09, 32'd0));
    // wrong node, then a continuation with nothing open
    send_frame(make_frame(8'h07, 8'd0, 4'd8, 8'h01, 32'd0));
    send_frame(make_frame(8'h08, 8'd1, 4'd8, 8'h01, 32'd0));
    send_frame(make_frame(8'h07, 8'd2, 4'd3, 8'h01, 32'd0));
    // wrong command, wrong sequence
    send_frame(make_frame(8'h07, 8'd0, 4'd8, 8'h01, 32'd0));
    send_frame(make_frame(8'h07, 8'd1, 4'd4, 8'h02, 32'd0));
    send_frame(make_frame(8'h07, 8'd0, 4'd8, 8'h01, 32'd0));
    send_frame(make_frame(8'h07, 8'd2, 4'd4, 8'h01, 32'd0));
    // store filled to the limit, closing bytes dropped, tick wraps
    clock_ms = 32'hFFFF_FFF8;
    for (int k = 0; k <= 9; k++)
      send_frame(make_frame(8'hA5, 8'(k), (k < 9) ? FULL_LEN : 4'd4, 8'h3C, 32'd1));
    // exactly at the timeout it survives, one past it is dropped
    send_frame(make_frame(8'h21, 8'd0, 4'd8, 8'h44, 32'd5));
    send_frame(make_frame(8'h21, 8'd1, 4'd8, 8'h44, 32'd100));
    send_frame(make_frame(8'h21, 8'd2, 4'd8, 8'h44, 32'd101));
    send_frame(make_frame(8'h21, 8'd3, 4'd3, 8'h44, 32'd1));
  endtask

  task automatic run_random(int unsigned target);
    int unsigned nfull;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          nfull = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 3);
          send_message(8'($urandom), 8'($urandom), nfull, 4'($urandom_range(1, 7)),
                       $urandom_range(0, 4) == 0);
        end
        6, 7: send_frame(make_frame(8'($urandom), 8'd0, 4'($urandom_range(1, 7)),
                                    8'($urandom), pick_step()));
        8: send_frame(make_frame(8'($urandom), 8'($urandom), 4'($urandom_range(0, 15)),
                                 8'($urandom), pick_step()));
        default: send_frame(make_frame(8'($urandom), 8'($urandom), 4'd0, 8'($urandom),
                                       pick_step()));
      endcase
    end
  endtask

  // result sink stalls on a pattern that changes now and then
  initial begin
    int unsigned mode;
    logic [7:0]  pat;
    int unsigned k;
    msg_ch.ready = 1'b1;
    k = 0;
    forever begin
      mode = $urandom_range(0, 2);
      pat  = 8'($urandom) | 8'h01;
      repeat ($urandom_range(16, 80)) begin
        @(negedge clk);
        case (mode)
          0:       msg_ch.ready = 1'b1;
          1:       msg_ch.ready = pat[k % 8];
          default: msg_ch.ready = (k % 4 == 0);
        endcase
        k++;
      end
    end
  end

  // check every message byte transfer
  always @(posedge clk) begin
    if (rst_n && msg_ch.valid && msg_ch.ready)
      sb.check_byte({msg_ch.node_id, msg_ch.command, msg_ch.payload_byte,
                     msg_ch.byte_valid, msg_ch.last_byte});
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((frame_ch.valid && frame_ch.ready) || (msg_ch.valid && msg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // main sequence
  initial begin
    logic [TMO_W-1:0] plan [4];
    sb                  = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    frame_ch.valid      = 1'b0;
    frame_ch.frame_node = '0;
    frame_ch.frame_seq  = '0;
    frame_ch.frame_len  = '0;
    frame_ch.byte0      = '0;
    frame_ch.byte1      = '0;
    frame_ch.byte2      = '0;
    frame_ch.byte3      = '0;
    frame_ch.byte4      = '0;
    frame_ch.byte5      = '0;
    frame_ch.byte6      = '0;
    frame_ch.byte7      = '0;
    frame_ch.now_ms     = '0;
    clock_ms            = '0;
    items_sent          = 0;
    burst_left          = 0;
    plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534))};

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // default timeout first, then a sweep of settings
    run_directed();
    run_random(items_sent + ITEMS_PER_PHASE);
    foreach (plan[i]) begin
      write_timeout(plan[i]);
      run_random(items_sent + ITEMS_PER_PHASE);
    end
    settle();

    if (sb.pending() != 0) begin
      $display("%0t: %0d message bytes never arrived", $time, sb.pending());
      sb.faults++;
    end
    if (sb.faults == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/can_mfr_pkg.sv
hw/rtl/can_mfr_if.sv
hw/rtl/can_mfr_queue.sv
hw/rtl/can_mfr_front.sv
hw/rtl/can_mfr_back.sv
hw/rtl/can_multi_frame_reassembler_unit.sv
hw/rtl/can_mfr_checker.sv
tb/sv/testbench.sv
